>>> src/wbm_pkg.sv
// ----------------------------------------------------------------------------
// wbm_pkg
// shared types and constants of the windowed bandwidth monitor
// ----------------------------------------------------------------------------
`default_nettype none

package wbm_pkg;

    // default counter width of the cumulative port counters
    localparam int COUNTER_BITS_DEF = 48;

    // field widths
    localparam int CYCLE_W  = 64;
    localparam int TOTAL_W  = 48;
    localparam int DELTA_W  = 48;
    localparam int RATE_W   = 48;
    localparam int UTIL_W   = 17;
    localparam int SCALE_W  = 32;
    localparam int TICKS_W  = 16;
    localparam int WIDE_W   = 64;

    // stream widths, packed lowest field first, padded to whole bytes
    localparam int IN_BITS  = CYCLE_W + 3 * TOTAL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * CYCLE_W + 3 * DELTA_W + 2 * RATE_W + 2 * UTIL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GBPS_SCALE   = 2'd2;

    localparam logic [TICKS_W-1:0] WINDOW_TICKS_RST = 16'd500;

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
    localparam logic [UTIL_W-1:0] UTIL_ONE = 17'h10000;

    // partial products per window close: low and high half of two deltas
    localparam int MUL_STEPS = 4;
    localparam int DIV_STEPS = 16;

    // controller to datapath
    typedef struct packed {
        logic       tick;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       sum_en;
        logic       div_start;
        logic       div_step;
        logic       out_load;
    } wbm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic close;
        logic out_full;
    } wbm_sts_t;

endpackage

`default_nettype wire

>>> src/wbm_div.sv
// ----------------------------------------------------------------------------
// wbm_div
// bit-serial fractional divider, busy over available as q1.16, clamped
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_div #(
    parameter int W = wbm_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      step,
    input  wire logic [W-1:0]              busy,
    input  wire logic [W-1:0]              avail,
    output      logic [wbm_pkg::UTIL_W-1:0] quot
);

    logic [W-1:0]               rem_reg, rem_next;
    logic [W-1:0]               den_reg, den_next;
    logic [wbm_pkg::UTIL_W-1:0] quot_reg, quot_next;
    logic                       fixed_reg, fixed_next;
    logic [W:0]                 rem2;
    logic                       take;

    assign rem2 = {rem_reg, 1'b0};
    assign take = (rem2 >= {1'b0, den_reg});

    always_comb
    begin
        rem_next   = rem_reg;
        den_next   = den_reg;
        quot_next  = quot_reg;
        fixed_next = fixed_reg;
        if (start)
        begin
            rem_next = busy;
            den_next = avail;
            if (avail == '0)
            begin
                quot_next  = '0;
                fixed_next = 1'b1;
            end
            else if (busy >= avail)
            begin
                quot_next  = wbm_pkg::UTIL_ONE;
                fixed_next = 1'b1;
            end
            else
            begin
                quot_next  = '0;
                fixed_next = 1'b0;
            end
        end
        else if (step && !fixed_reg)
        begin
            // remainder stays below the divisor, so the difference fits W bits
            if (take)
            begin
                rem_next = W'(rem2 - {1'b0, den_reg});
            end
            else
            begin
                rem_next = rem2[W-1:0];
            end
            quot_next = {quot_reg[wbm_pkg::UTIL_W-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_reg <= 1'b1;
        end
        else
        begin
            fixed_reg <= fixed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

>>> src/wbm_ctrl.sv
// ----------------------------------------------------------------------------
// wbm_ctrl
// sequencer: tick intake, multiply steps, rate sum, divide steps, output load
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire wbm_pkg::wbm_sts_t sts,
    output      wbm_pkg::wbm_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SUM  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    localparam logic [3:0] MUL_LAST = 4'(wbm_pkg::MUL_STEPS - 1);
    localparam logic [3:0] DIV_LAST = 4'(wbm_pkg::DIV_STEPS - 1);

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       fire;

    assign in_ready = (state_reg == S_IDLE);
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.tick   = fire;
        cmd.mul_sel = cnt_reg[1:0];
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (fire && sts.close)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                cnt_next   = cnt_reg + 4'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_en    = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> src/wbm_dp.sv
// ----------------------------------------------------------------------------
// wbm_dp
// datapath: config registers, window state, deltas, rates, dividers, output
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_dp #(
    parameter int COUNTER_BITS = wbm_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [wbm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [wbm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [wbm_pkg::IN_W-1:0]      in_data,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [wbm_pkg::OUT_W-1:0]     out_data,
    input  wire wbm_pkg::wbm_cmd_t             cmd,
    output      wbm_pkg::wbm_sts_t             sts
);

    localparam int CB  = COUNTER_BITS;
    localparam int CW  = wbm_pkg::CYCLE_W;
    localparam int TW  = wbm_pkg::TOTAL_W;
    localparam int WW  = wbm_pkg::WIDE_W;
    localparam int RW  = wbm_pkg::RATE_W;
    localparam int UW  = wbm_pkg::UTIL_W;
    localparam int NW  = wbm_pkg::TICKS_W;
    localparam int SW  = wbm_pkg::SCALE_W;

    // config
    logic          enable_reg;
    logic [NW-1:0] ticks_reg;
    logic [SW-1:0] scale_reg;

    // window state
    logic [NW-1:0] count_reg;
    logic          open_reg;
    logic [CW-1:0] begin_reg;
    logic [CB-1:0] last_av_reg, last_db_reg, last_fb_reg;

    // per-window results under work
    logic [CW-1:0] res_begin_reg, res_end_reg;
    logic [CB-1:0] d_av_reg, d_db_reg, d_fb_reg;
    logic [WW-1:0] pp_reg [wbm_pkg::MUL_STEPS];
    logic [RW-1:0] rate_d_reg, rate_f_reg;

    // output register
    logic          out_valid_reg;
    logic [wbm_pkg::OUT_W-1:0] out_data_reg;

    // input unpack
    logic [CW-1:0] in_cycle;
    logic [WW-1:0] av_wide, db_wide, fb_wide;
    logic [CB-1:0] av_now, db_now, fb_now;

    // tick decision
    logic [NW-1:0] count_inc, win_len;
    logic          close;

    // deltas widened for the multiplier
    logic [WW-1:0] d_db_wide, d_fb_wide, d_av_wide;
    logic [31:0]   mul_a;
    logic [WW-1:0] mul_p;

    // rate sums
    logic [WW-1:0] sum_d, sum_f;
    logic [RW-1:0] rate_d, rate_f;

    logic [UW-1:0] util_d, util_f;

    assign in_cycle = in_data[CW-1:0];
    assign av_wide  = WW'(in_data[CW +: TW]);
    assign db_wide  = WW'(in_data[CW + TW +: TW]);
    assign fb_wide  = WW'(in_data[CW + 2 * TW +: TW]);
    assign av_now   = av_wide[CB-1:0];
    assign db_now   = db_wide[CB-1:0];
    assign fb_now   = fb_wide[CB-1:0];

    // zero window length behaves as one
    assign win_len   = (ticks_reg == '0) ? NW'(1) : ticks_reg;
    assign count_inc = open_reg ? NW'(count_reg + NW'(1)) : NW'(1);
    assign close     = enable_reg && (count_inc >= win_len);

    assign sts.close    = close;
    assign sts.out_full = out_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            ticks_reg  <= wbm_pkg::WINDOW_TICKS_RST;
            scale_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                wbm_pkg::CFG_ENABLE:       enable_reg <= cfg_data[0];
                wbm_pkg::CFG_WINDOW_TICKS: ticks_reg  <= cfg_data[NW-1:0];
                wbm_pkg::CFG_GBPS_SCALE:   scale_reg  <= cfg_data[SW-1:0];
                default:                   ;
            endcase
        end
    end

    // window state and last totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            open_reg    <= 1'b0;
            begin_reg   <= '0;
            last_av_reg <= '0;
            last_db_reg <= '0;
            last_fb_reg <= '0;
        end
        else if (cmd.tick && enable_reg)
        begin
            if (close)
            begin
                count_reg   <= '0;
                open_reg    <= 1'b0;
                begin_reg   <= '0;
                last_av_reg <= av_now;
                last_db_reg <= db_now;
                last_fb_reg <= fb_now;
            end
            else
            begin
                count_reg <= count_inc;
                open_reg  <= 1'b1;
                if (!open_reg)
                begin
                    begin_reg <= in_cycle;
                end
            end
        end
    end

    // capture of a closing tick
    always_ff @(posedge clk)
    begin
        if (cmd.tick && close)
        begin
            res_begin_reg <= open_reg ? begin_reg : in_cycle;
            res_end_reg   <= in_cycle;
            d_av_reg      <= CB'(av_now - last_av_reg);
            d_db_reg      <= CB'(db_now - last_db_reg);
            d_fb_reg      <= CB'(fb_now - last_fb_reg);
        end
    end

    assign d_av_wide = WW'(d_av_reg);
    assign d_db_wide = WW'(d_db_reg);
    assign d_fb_wide = WW'(d_fb_reg);

    // one 32x32 multiplier, one partial product a step
    always_comb
    begin
        case (cmd.mul_sel)
            2'd0:    mul_a = d_db_wide[31:0];
            2'd1:    mul_a = d_db_wide[63:32];
            2'd2:    mul_a = d_fb_wide[31:0];
            default: mul_a = d_fb_wide[63:32];
        endcase
    end

    assign mul_p = {32'b0, mul_a} * {32'b0, scale_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            pp_reg[cmd.mul_sel] <= mul_p;
        end
    end

    // (busy * scale) >> 8 from the two halves, saturating
    assign sum_d = {pp_reg[1][23:0], 40'b0} >> 16;
    assign sum_f = {pp_reg[3][23:0], 40'b0} >> 16;

    always_comb
    begin
        logic [WW-1:0] s_d;
        logic [WW-1:0] s_f;
        s_d = sum_d + {8'b0, pp_reg[0][63:8]};
        s_f = sum_f + {8'b0, pp_reg[2][63:8]};
        if ((pp_reg[1][63:24] != '0) || (s_d[63:48] != '0))
        begin
            rate_d = wbm_pkg::RATE_MAX;
        end
        else
        begin
            rate_d = s_d[RW-1:0];
        end
        if ((pp_reg[3][63:24] != '0) || (s_f[63:48] != '0))
        begin
            rate_f = wbm_pkg::RATE_MAX;
        end
        else
        begin
            rate_f = s_f[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            rate_d_reg <= rate_d;
            rate_f_reg <= rate_f;
        end
    end

    wbm_div #(
        .W (CB)
    ) u_div_data (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .step  (cmd.div_step),
        .busy  (d_db_reg),
        .avail (d_av_reg),
        .quot  (util_d)
    );

    wbm_div #(
        .W (CB)
    ) u_div_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .step  (cmd.div_step),
        .busy  (d_fb_reg),
        .avail (d_av_reg),
        .quot  (util_f)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= wbm_pkg::OUT_W'({util_f, util_d, rate_f_reg, rate_d_reg,
                                             d_fb_wide[47:0], d_db_wide[47:0],
                                             d_av_wide[47:0], res_end_reg,
                                             res_begin_reg});
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> src/windowed_bandwidth_monitor.sv
// ----------------------------------------------------------------------------
// windowed_bandwidth_monitor
// per-window port bandwidth and utilisation figures from cumulative counters
// ----------------------------------------------------------------------------
// Takes one tick beat a cycle while s_tready is high; each beat carries the
// cycle number and three cumulative counters. A tick that does not close the
// window is taken without a stall, so such ticks stream back to back. A tick
// that closes the window starts a sequence during which s_tready is low: the
// multiply steps on the shared 32x32 multiplier (low and high half of each
// busy delta times gbps_scale), a step to add and saturate the rates, the
// steps of the two bit-serial dividers that make the q1.16 utilisations, then
// the load of the output register. Ticks are taken again while that result
// waits on m_tvalid; a further closing tick then stalls in the load step until
// the previous result has been taken. Configuration is written through cfg_*,
// which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_bandwidth_monitor #(
    parameter int COUNTER_BITS = wbm_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // configuration write channel
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [wbm_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [wbm_pkg::CFG_DATA_W-1:0]  cfg_data,

    // tick stream
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // cycle[63:0], total_available[47:0], total_data_busy[47:0],
    // total_fill_busy[47:0]
    input  wire logic [wbm_pkg::IN_W-1:0]        s_tdata,

    // result stream
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // window_begin[63:0], window_end[63:0], avail_delta[47:0],
    // data_busy_delta[47:0], fill_busy_delta[47:0], data_rate[47:0],
    // fill_rate[47:0], data_utilization[16:0], fill_utilization[16:0],
    // zero padding
    output      logic [wbm_pkg::OUT_W-1:0]       m_tdata
);

    // command and status between sequencer and datapath
    wbm_pkg::wbm_cmd_t cmd;
    wbm_pkg::wbm_sts_t sts;

    // sequencer owns s_tready and steps the datapath through a window close
    wbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath holds config, window state, arithmetic and the output register
    wbm_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    // a closing tick always hands over to the sequence and drops s_tready
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && sts.close) |=> !s_tready)
        else $error("closing tick did not stall the tick stream");

    // the output register is only loaded when empty
    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !m_tvalid)
        else $error("result loaded over a pending beat");

    // at most one datapath step at a time
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mul_en, cmd.div_start, cmd.div_step, cmd.out_load}))
        else $error("overlapping datapath commands");

    // utilisations never exceed one
    a_util_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[384:368] <= wbm_pkg::UTIL_ONE)
                   && (m_tdata[401:385] <= wbm_pkg::UTIL_ONE)))
        else $error("utilisation above one");

endmodule

`default_nettype wire
